// ===== rtl/wavhp_pkg.sv =====
// wavhp_pkg: types and constants shared by the wav header parser
// word types for the byte and result channels, parse phases, tags, status codes
// no dependencies
package wavhp_pkg;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  format_code;
        logic [31:0] sample_rate;
        logic [31:0] data_size;
        logic [31:0] data_offset;
    } out_word_t;

    localparam logic [2:0] PH_RIFF  = 3'd0;
    localparam logic [2:0] PH_RSIZE = 3'd1;
    localparam logic [2:0] PH_WAVE  = 3'd2;
    localparam logic [2:0] PH_HDR   = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;
    localparam logic [2:0] PH_PAD   = 3'd5;
    localparam logic [2:0] PH_HALT  = 3'd6;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_RIFF = 3'd1;
    localparam logic [2:0] ST_NO_WAVE = 3'd2;
    localparam logic [2:0] ST_NO_FMT  = 3'd3;
    localparam logic [2:0] ST_NO_DATA = 3'd4;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NO_RIFF = 2'd1;
    localparam logic [1:0] ERR_NO_WAVE = 2'd2;

    localparam logic [1:0] FMT_MONO8    = 2'd0;
    localparam logic [1:0] FMT_MONO16   = 2'd1;
    localparam logic [1:0] FMT_STEREO8  = 2'd2;
    localparam logic [1:0] FMT_STEREO16 = 2'd3;

    localparam logic [4:0] FMT_SPAN  = 5'd16;
    localparam logic [4:0] HDR_BYTES = 5'd8;
    localparam logic [4:0] MAGIC_LEN = 5'd4;

endpackage

// ===== rtl/wavhp_core.sv =====
// wavhp_core: per-byte parse state and the result formed on the last byte
// depends on wavhp_pkg
module wavhp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  wavhp_pkg::in_word_t  in_word,
    output logic                 res_fire,
    output wavhp_pkg::out_word_t res_word
);

    logic [31:0] pos_reg,   pos_next;
    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  err_reg,   err_next;
    logic [31:0] tag_reg,   tag_next;
    logic [31:0] len_reg,   len_next;
    logic [31:0] left_reg,  left_next;
    logic [4:0]  idx_reg,   idx_next;
    logic        in_fmt_reg, in_fmt_next;
    logic [15:0] chan_reg,  chan_next;
    logic [15:0] bits_reg,  bits_next;
    logic [31:0] rate_reg,  rate_next;
    logic        saw_fmt_reg, saw_fmt_next;
    logic        saw_data_reg, saw_data_next;
    logic [31:0] dlen_reg,  dlen_next;
    logic [31:0] dstart_reg, dstart_next;
    logic        pad_reg,   pad_next;

    logic [7:0]  b;
    logic [2:0]  status;
    logic [1:0]  code;

    assign b = in_word.file_byte;

    always_comb begin
        pos_next      = pos_reg + 32'd1;
        phase_next    = phase_reg;
        err_next      = err_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        left_next     = left_reg;
        idx_next      = idx_reg;
        in_fmt_next   = in_fmt_reg;
        chan_next     = chan_reg;
        bits_next     = bits_reg;
        rate_next     = rate_reg;
        saw_fmt_next  = saw_fmt_reg;
        saw_data_next = saw_data_reg;
        dlen_next     = dlen_reg;
        dstart_next   = dstart_reg;
        pad_next      = pad_reg;

        unique case (phase_reg) inside
            wavhp_pkg::PH_RIFF, wavhp_pkg::PH_WAVE: begin
                tag_next = {tag_reg[23:0], b};
                idx_next = idx_reg + 5'd1;
                if (idx_next == wavhp_pkg::MAGIC_LEN) begin
                    idx_next = '0;
                    if (phase_reg == wavhp_pkg::PH_RIFF) begin
                        if (tag_next != wavhp_pkg::TAG_RIFF) begin
                            err_next   = wavhp_pkg::ERR_NO_RIFF;
                            phase_next = wavhp_pkg::PH_HALT;
                        end else begin
                            phase_next = wavhp_pkg::PH_RSIZE;
                        end
                    end else begin
                        if (tag_next != wavhp_pkg::TAG_WAVE) begin
                            err_next   = wavhp_pkg::ERR_NO_WAVE;
                            phase_next = wavhp_pkg::PH_HALT;
                        end else begin
                            phase_next = wavhp_pkg::PH_HDR;
                        end
                    end
                end
            end
            wavhp_pkg::PH_RSIZE: begin
                idx_next = idx_reg + 5'd1;
                if (idx_next == wavhp_pkg::MAGIC_LEN) begin
                    idx_next   = '0;
                    phase_next = wavhp_pkg::PH_WAVE;
                end
            end
            wavhp_pkg::PH_HDR: begin
                if (idx_reg < wavhp_pkg::MAGIC_LEN) begin
                    tag_next = {tag_reg[23:0], b};
                end else begin
                    len_next = {b, len_reg[31:8]};
                end
                idx_next = idx_reg + 5'd1;
                if (idx_next == wavhp_pkg::HDR_BYTES) begin
                    idx_next    = '0;
                    in_fmt_next = 1'b0;
                    if (tag_next == wavhp_pkg::TAG_FMT) begin
                        saw_fmt_next = 1'b1;
                        in_fmt_next  = 1'b1;
                        chan_next    = '0;
                        bits_next    = '0;
                        rate_next    = '0;
                    end else if (tag_next == wavhp_pkg::TAG_DATA) begin
                        saw_data_next = 1'b1;
                        dlen_next     = len_next;
                        dstart_next   = pos_reg + 32'd1;
                    end
                    left_next  = len_next;
                    pad_next   = len_next[0];
                    phase_next = (len_next != '0) ? wavhp_pkg::PH_BODY : wavhp_pkg::PH_HDR;
                end
            end
            wavhp_pkg::PH_BODY: begin
                if (in_fmt_reg && idx_reg < wavhp_pkg::FMT_SPAN) begin
                    case (idx_reg[3:0])
                        4'd2:    chan_next[7:0]   = b;
                        4'd3:    chan_next[15:8]  = b;
                        4'd4:    rate_next[7:0]   = b;
                        4'd5:    rate_next[15:8]  = b;
                        4'd6:    rate_next[23:16] = b;
                        4'd7:    rate_next[31:24] = b;
                        4'd14:   bits_next[7:0]   = b;
                        4'd15:   bits_next[15:8]  = b;
                        default: ;
                    endcase
                    idx_next = idx_reg + 5'd1;
                end
                left_next = left_reg - 32'd1;
                if (left_reg == 32'd1) begin
                    idx_next    = '0;
                    in_fmt_next = 1'b0;
                    phase_next  = pad_reg ? wavhp_pkg::PH_PAD : wavhp_pkg::PH_HDR;
                    pad_next    = 1'b0;
                end
            end
            wavhp_pkg::PH_PAD: begin
                phase_next = wavhp_pkg::PH_HDR;
            end
            default: ;
        endcase
    end

    // result seen after this byte is parsed
    always_comb begin
        if (phase_next == wavhp_pkg::PH_RIFF) begin
            status = wavhp_pkg::ST_NO_RIFF;
        end else if (phase_next == wavhp_pkg::PH_RSIZE || phase_next == wavhp_pkg::PH_WAVE) begin
            status = wavhp_pkg::ST_NO_WAVE;
        end else if (err_next != wavhp_pkg::ERR_NONE) begin
            status = {1'b0, err_next};
        end else if (!saw_fmt_next) begin
            status = wavhp_pkg::ST_NO_FMT;
        end else if (!saw_data_next) begin
            status = wavhp_pkg::ST_NO_DATA;
        end else begin
            status = wavhp_pkg::ST_OK;
        end

        if (chan_next == 16'd1) begin
            code = (bits_next == 16'd8) ? wavhp_pkg::FMT_MONO8 : wavhp_pkg::FMT_MONO16;
        end else begin
            code = (bits_next == 16'd8) ? wavhp_pkg::FMT_STEREO8 : wavhp_pkg::FMT_STEREO16;
        end

        res_word.status = status;
        if (status == wavhp_pkg::ST_OK) begin
            res_word.format_code = code;
            res_word.sample_rate = rate_next;
            res_word.data_size   = dlen_next;
            res_word.data_offset = dstart_next;
        end else begin
            res_word.format_code = wavhp_pkg::FMT_MONO8;
            res_word.sample_rate = '0;
            res_word.data_size   = '0;
            res_word.data_offset = '0;
        end
    end

    assign res_fire = in_fire && in_word.end_of_file;

    always_ff @(posedge aclk) begin
        if (!aresetn || res_fire) begin
            pos_reg      <= '0;
            phase_reg    <= wavhp_pkg::PH_RIFF;
            err_reg      <= wavhp_pkg::ERR_NONE;
            tag_reg      <= '0;
            len_reg      <= '0;
            left_reg     <= '0;
            idx_reg      <= '0;
            in_fmt_reg   <= 1'b0;
            chan_reg     <= '0;
            bits_reg     <= '0;
            rate_reg     <= '0;
            saw_fmt_reg  <= 1'b0;
            saw_data_reg <= 1'b0;
            dlen_reg     <= '0;
            dstart_reg   <= '0;
            pad_reg      <= 1'b0;
        end else if (in_fire) begin
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            err_reg      <= err_next;
            tag_reg      <= tag_next;
            len_reg      <= len_next;
            left_reg     <= left_next;
            idx_reg      <= idx_next;
            in_fmt_reg   <= in_fmt_next;
            chan_reg     <= chan_next;
            bits_reg     <= bits_next;
            rate_reg     <= rate_next;
            saw_fmt_reg  <= saw_fmt_next;
            saw_data_reg <= saw_data_next;
            dlen_reg     <= dlen_next;
            dstart_reg   <= dstart_next;
            pad_reg      <= pad_next;
        end
    end

endmodule

// ===== rtl/wav_header_parser.sv =====
// wav_header_parser: top level, byte channel in, one result word per file out
// depends on wavhp_pkg and wavhp_core
//
// usage
//   s_ channel carries one file byte per word, end_of_file set on the last byte
//   m_ channel carries one result word per file: status, format code, sample
//   rate, data chunk size and data chunk offset
//   a new byte can be taken on every clock edge while s_ready is high
//   the result word appears on m_ in the cycle after the last byte is accepted
//   the parse state sits in the core registers, the result in an output register
//   while a result is held and m_ready is low, s_ready is low and the next
//   byte waits; once the result is taken bytes flow again
//   after the last byte the parse state returns to its reset values
//   reset (aresetn low, synchronous) clears parse state and empties the output
module wav_header_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wavhp_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wavhp_pkg::out_word_t m_data
);

    logic                 m_valid_reg, m_valid_next;
    wavhp_pkg::out_word_t m_data_reg;
    logic                 in_fire;
    logic                 res_fire;
    wavhp_pkg::out_word_t res_word;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    wavhp_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_word  (s_data),
        .res_fire (res_fire),
        .res_word (res_word)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_fire) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_fire) begin
            m_data_reg <= res_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/wavhp_checker.sv =====
// wavhp_checker: port-level checks on the wav header parser, with its bind
// depends on wavhp_pkg and wav_header_parser
module wavhp_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input wavhp_pkg::in_word_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input wavhp_pkg::out_word_t m_data
);

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // last byte always yields a result next cycle
    a_eof_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.end_of_file |=> m_valid)
        else $error("no result after last byte");

    // a non-final byte never creates a result
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.end_of_file && (!m_valid || m_ready) |=> !m_valid)
        else $error("result without last byte");

    // input stalls only behind a held result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with output free");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != wavhp_pkg::ST_OK |->
            m_data.format_code == 2'd0 && m_data.sample_rate == 32'd0 &&
            m_data.data_size == 32'd0 && m_data.data_offset == 32'd0)
        else $error("error result with nonzero fields");

endmodule

bind wav_header_parser wavhp_checker u_wavhp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
